// ===== sv/spline_path_eval_at_arc_length_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spline path evaluator
// Implication forms clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SPLINE_PATH_EVAL_AT_ARC_LENGTH_MACROS_SVH
`define SPLINE_PATH_EVAL_AT_ARC_LENGTH_MACROS_SVH

// same-cycle implication
`define SPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spe assertion failed");

// next-cycle implication
`define SPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spe assertion failed");

`endif

// ===== sv/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, codes and arithmetic helpers of the spline path evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_FRAC_BITS    = 24;
    localparam int DEF_WORD_BITS    = 48;

    localparam int SEG_BITS      = 6;
    localparam int WIDX_BITS     = 4;
    localparam int CFG_BITS      = 7;
    localparam int WORDS_PER_SEG = 12;
    localparam int AXIS_WORDS    = 6;
    localparam int STEP_BITS     = 4;

    localparam logic                 OP_WRITE  = 1'b0;
    localparam logic                 OP_EVAL   = 1'b1;
    localparam logic [WIDX_BITS-1:0] WORD_LEN  = 4'd12;
    localparam logic [STEP_BITS-1:0] LAST_STEP = 4'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_DIV_SET,
        ST_DIV_CHK,
        ST_DIV,
        ST_FETCH,
        ST_SCALE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PROD,
        ST_ACC,
        ST_STORE,
        ST_FINISH
    } state_t;

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] t;
        t = 65'(a) + 65'(b);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] t;
        t = 65'(a) - 65'(b);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] sat_scale(logic signed [63:0] a,
                                                     logic [4:0] k);
        logic signed [69:0] p;
        p = 70'(a) * signed'(70'(k));
        if (p > 70'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (p < -70'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return p[63:0];
    endfunction

    // Horner programme: position a5..a0, first derivative, second derivative
    function automatic logic [2:0] step_word(logic [STEP_BITS-1:0] st);
        case (st)
            4'd0, 4'd6, 4'd11: return 3'd5;
            4'd1, 4'd7, 4'd12: return 3'd4;
            4'd2, 4'd8, 4'd13: return 3'd3;
            4'd3, 4'd9, 4'd14: return 3'd2;
            4'd4, 4'd10:       return 3'd1;
            default:           return 3'd0;
        endcase
    endfunction

    function automatic logic [4:0] step_scale(logic [STEP_BITS-1:0] st);
        case (st)
            4'd6:        return 5'd5;
            4'd7:        return 5'd4;
            4'd8:        return 5'd3;
            4'd9, 4'd14: return 5'd2;
            4'd11:       return 5'd20;
            4'd12:       return 5'd12;
            4'd13:       return 5'd6;
            default:     return 5'd1;
        endcase
    endfunction

    function automatic logic step_init(logic [STEP_BITS-1:0] st);
        return (st == 4'd0) || (st == 4'd6) || (st == 4'd11);
    endfunction

    function automatic logic step_last(logic [STEP_BITS-1:0] st);
        return (st == 4'd5) || (st == 4'd10) || (st == LAST_STEP);
    endfunction

    function automatic logic [1:0] step_kind(logic [STEP_BITS-1:0] st);
        if (st <= 4'd5) return 2'd0;
        if (st <= 4'd10) return 2'd1;
        return 2'd2;
    endfunction

endpackage

// ===== sv/spe_table.sv =====
// ----------------------------------------------------------------------------
// spe_table
// Coefficient and segment length memories, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module spe_table import spe_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int WORD_BITS    = DEF_WORD_BITS,
    parameter int AW           = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    parameter int CAW          = $clog2(MAX_SEGMENTS * WORDS_PER_SEG)
) (
    input  logic                 aclk,
    input  logic                 coef_we,
    input  logic [CAW-1:0]       coef_waddr,
    input  logic [WORD_BITS-1:0] coef_wdata,
    input  logic [CAW-1:0]       coef_raddr,
    output logic [WORD_BITS-1:0] coef_rdata,
    input  logic                 len_we,
    input  logic [AW-1:0]        len_waddr,
    input  logic [WORD_BITS-1:0] len_wdata,
    input  logic [AW-1:0]        len_raddr,
    output logic [WORD_BITS-1:0] len_rdata
);

    logic [WORD_BITS-1:0] coef_mem [MAX_SEGMENTS * WORDS_PER_SEG];
    logic [WORD_BITS-1:0] len_mem  [MAX_SEGMENTS];

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rdata <= coef_mem[coef_raddr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

// ===== sv/spline_path_eval_at_arc_length.sv =====
// ----------------------------------------------------------------------------
// spline_path_eval_at_arc_length
// Quintic path table with evaluation of position and derivatives at an arc
// length.
//
// Input channel (s_*): op 0 writes one table word and gives no result; op 1
// evaluates the path at s_arc_query and gives one result on m_*. cfg_* writes
// the segment count; it is always ready.
// An evaluate request runs these steps for the n segments in use: one read
// of the length table per cycle for the total, a read and a compare state
// per segment in the walk, a restoring division that gives up to FRAC_BITS
// quotient bits, and 30 Horner steps on the shared 32-bit multiplier, two
// passes per product. s_ready is low while an evaluation runs. A finished
// result waits in the output register while the receiver stalls; the next
// request is taken meanwhile, and its own result waits until the register
// is free.
// Reset clears the control state and the segment count; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
module spline_path_eval_at_arc_length import spe_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int WORD_BITS    = DEF_WORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_BITS-1:0]    cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [SEG_BITS-1:0]    s_seg_index,
    input  logic [WIDX_BITS-1:0]   s_word_index,
    input  logic [WORD_BITS-1:0]   s_value,
    input  logic [WORD_BITS-2:0]   s_arc_query,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_valid_res,
    output logic [SEG_BITS-1:0]    m_seg_found,
    output logic [FRAC_BITS:0]     m_u_param,
    output logic [WORD_BITS-1:0]   m_pos_x,
    output logic [WORD_BITS-1:0]   m_pos_y,
    output logic [WORD_BITS-1:0]   m_vel_x,
    output logic [WORD_BITS-1:0]   m_vel_y,
    output logic [WORD_BITS-1:0]   m_acc_x,
    output logic [WORD_BITS-1:0]   m_acc_y
);

    localparam int UW  = FRAC_BITS + 1;
    localparam int PW  = 32 + UW;
    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int IW  = $clog2(MAX_SEGMENTS + 1);
    localparam int CAW = $clog2(MAX_SEGMENTS * WORDS_PER_SEG);
    localparam int DCW = $clog2(FRAC_BITS + 1);
    localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC_BITS;
    localparam logic signed [63:0] WMAX =
        signed'(64'((64'd1 << (WORD_BITS - 1)) - 64'd1));
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]     segcnt_reg;
    logic [IW-1:0]           n_reg, n_next, n_sat;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic signed [63:0]      total_reg, total_next;
    logic signed [63:0]      s_reg, s_next;
    logic signed [63:0]      start_reg, start_next;
    logic signed [63:0]      diff_reg, diff_next;
    logic [63:0]             div_reg, div_next;
    logic [63:0]             rem_reg, rem_next;
    logic [DCW-1:0]          dcnt_reg, dcnt_next;
    logic [UW-1:0]           u_reg, u_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic                    axis_reg, axis_next;
    logic signed [63:0]      acc_reg, acc_next;
    logic signed [63:0]      addend_reg, addend_next;
    logic [63:0]             mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [PW-1:0]           plo_reg, plo_next;
    logic [PW-1:0]           phi_reg, phi_next;
    logic [63:0]             r_reg, r_next;
    logic                    ok_reg, ok_next;
    logic [WORD_BITS-1:0]    res_reg [6];
    logic [WORD_BITS-1:0]    res_next [6];

    logic                    m_valid_reg;
    logic                    m_load;

    logic                    s_fire;
    logic                    wr_fire;
    logic [WORD_BITS-1:0]    coef_rdata, len_rdata;
    logic signed [63:0]      coef_sx, len_sx;
    logic [CAW-1:0]          coef_raddr, coef_waddr;
    logic                    more_seg;
    logic signed [63:0]      walk_nxt;
    logic [64:0]             div_trial;
    logic signed [65:0]      acc_sum;
    logic signed [63:0]      scaled;
    logic [2:0]              res_sel;
    logic [31:0]             mul_a;
    logic [PW-1:0]           mul_p;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign wr_fire   = s_fire && (s_op == OP_WRITE)
                       && (32'(s_seg_index) < MAX_SEGMENTS) && (s_word_index <= WORD_LEN);

    assign coef_waddr = CAW'(s_seg_index) * CAW'(WORDS_PER_SEG) + CAW'(s_word_index);
    assign coef_raddr = CAW'(idx_reg[AW-1:0]) * CAW'(WORDS_PER_SEG)
                        + (axis_reg ? CAW'(AXIS_WORDS) : CAW'(0))
                        + CAW'(step_word(step_reg));

    spe_table #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .WORD_BITS    (WORD_BITS),
        .AW           (AW),
        .CAW          (CAW)
    ) u_table (
        .aclk       (aclk),
        .coef_we    (wr_fire && (s_word_index != WORD_LEN)),
        .coef_waddr (coef_waddr),
        .coef_wdata (s_value),
        .coef_raddr (coef_raddr),
        .coef_rdata (coef_rdata),
        .len_we     (wr_fire && (s_word_index == WORD_LEN)),
        .len_waddr  (AW'(s_seg_index)),
        .len_wdata  (s_value),
        .len_raddr  (idx_reg[AW-1:0]),
        .len_rdata  (len_rdata)
    );

    assign coef_sx  = 64'(signed'(coef_rdata));
    assign len_sx   = 64'(signed'(len_rdata));
    assign n_sat    = (32'(segcnt_reg) > MAX_SEGMENTS) ? IW'(MAX_SEGMENTS) : IW'(segcnt_reg);
    assign more_seg = ((IW+1)'(idx_reg) + (IW+1)'(1)) < (IW+1)'(n_reg);
    assign walk_nxt = sat_add(start_reg, len_sx);
    assign div_trial = {rem_reg, 1'b0};
    assign acc_sum  = neg_reg ? (66'(addend_reg) - signed'({2'b00, r_reg}))
                              : (66'(addend_reg) + signed'({2'b00, r_reg}));
    assign scaled   = sat_scale(coef_sx, step_scale(step_reg));
    assign res_sel  = 3'({step_kind(step_reg), 1'b0}) + 3'(axis_reg);
    assign m_load   = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign mul_a    = (state_reg == ST_MUL_HI) ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_p    = PW'(mul_a) * PW'(u_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_EVAL)) begin
                    state_next = (n_sat == '0) ? ST_FINISH : ST_SUM;
                end
            end
            ST_SUM: begin
                if (idx_reg == n_reg) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:    state_next = (total_reg <= 64'sd0) ? ST_FINISH : ST_WALK_RD;
            ST_WALK_RD:  state_next = ST_WALK_CMP;
            ST_WALK_CMP: state_next = (more_seg && (walk_nxt < s_reg)) ? ST_WALK_RD : ST_DIV_SET;
            ST_DIV_SET:  state_next = ST_DIV_CHK;
            ST_DIV_CHK: begin
                if ((diff_reg <= 64'sd0) || (unsigned'(diff_reg) >= div_reg)) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == DCW'(FRAC_BITS - 1)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:  state_next = ST_SCALE;
            ST_SCALE:  state_next = step_init(step_reg) ? ST_FETCH : ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_PROD;
            ST_PROD:   state_next = ST_ACC;
            ST_ACC:    state_next = step_last(step_reg) ? ST_STORE : ST_FETCH;
            ST_STORE: begin
                if ((step_reg == LAST_STEP) && axis_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        n_next      = n_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        total_next  = total_reg;
        s_next      = s_reg;
        start_next  = start_reg;
        diff_next   = diff_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        u_next      = u_reg;
        step_next   = step_reg;
        axis_next   = axis_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        r_next      = r_reg;
        ok_next     = ok_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_EVAL)) begin
                    n_next     = n_sat;
                    s_next     = signed'(64'(s_arc_query));
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    total_next = 64'sd0;
                    ok_next    = 1'b0;
                    u_next     = '0;
                    for (int i = 0; i < 6; i++) begin
                        res_next[i] = '0;
                    end
                end
            end
            ST_SUM: begin
                if (pend_reg) begin
                    total_next = sat_add(total_reg, len_sx);
                end
                if (idx_reg < n_reg) begin
                    idx_next  = idx_reg + IW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_CHECK: begin
                idx_next   = '0;
                start_next = 64'sd0;
                if (s_reg > total_reg) begin
                    s_next = total_reg;
                end
            end
            ST_WALK_CMP: begin
                if (more_seg && (walk_nxt < s_reg)) begin
                    start_next = walk_nxt;
                    idx_next   = idx_reg + IW'(1);
                end
            end
            ST_DIV_SET: begin
                div_next  = (len_sx < 64'sd1) ? 64'd1 : unsigned'(len_sx);
                diff_next = sat_sub(s_reg, start_reg);
            end
            ST_DIV_CHK: begin
                ok_next   = 1'b1;
                step_next = '0;
                axis_next = 1'b0;
                dcnt_next = '0;
                rem_next  = unsigned'(diff_reg);
                if (diff_reg <= 64'sd0) begin
                    u_next = '0;
                end else if (unsigned'(diff_reg) >= div_reg) begin
                    u_next = U_ONE;
                end else begin
                    u_next = '0;
                end
            end
            ST_DIV: begin
                dcnt_next = dcnt_reg + DCW'(1);
                if (div_trial >= {1'b0, div_reg}) begin
                    rem_next = 64'(div_trial - {1'b0, div_reg});
                    u_next   = {u_reg[UW-2:0], 1'b1};
                end else begin
                    rem_next = div_trial[63:0];
                    u_next   = {u_reg[UW-2:0], 1'b0};
                end
            end
            ST_SCALE: begin
                if (step_init(step_reg)) begin
                    acc_next  = scaled;
                    step_next = step_reg + STEP_BITS'(1);
                end else begin
                    addend_next = scaled;
                    neg_next    = acc_reg[63];
                    mag_next    = acc_reg[63] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
                end
            end
            ST_MUL_LO: plo_next = mul_p;
            ST_MUL_HI: phi_next = mul_p;
            ST_PROD: begin
                r_next = (64'(phi_reg) << (32 - FRAC_BITS)) + 64'(plo_reg >> FRAC_BITS);
            end
            ST_ACC: begin
                if (acc_sum > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
                    acc_next = 64'sh7FFF_FFFF_FFFF_FFFF;
                end else if (acc_sum < -66'sh0_8000_0000_0000_0000) begin
                    acc_next = 64'sh8000_0000_0000_0000;
                end else begin
                    acc_next = acc_sum[63:0];
                end
                if (!step_last(step_reg)) begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            ST_STORE: begin
                if (acc_reg > WMAX) begin
                    res_next[res_sel] = WORD_BITS'(WMAX);
                end else if (acc_reg < WMIN) begin
                    res_next[res_sel] = WORD_BITS'(WMIN);
                end else begin
                    res_next[res_sel] = WORD_BITS'(acc_reg);
                end
                if (step_reg == LAST_STEP) begin
                    step_next = '0;
                    axis_next = 1'b1;
                end else begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            segcnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                segcnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        total_reg  <= total_next;
        s_reg      <= s_next;
        start_reg  <= start_next;
        diff_reg   <= diff_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        u_reg      <= u_next;
        step_reg   <= step_next;
        axis_reg   <= axis_next;
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        r_reg      <= r_next;
        ok_reg     <= ok_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_valid_res <= ok_reg;
            m_seg_found <= SEG_BITS'(idx_reg);
            m_u_param   <= u_reg;
            m_pos_x     <= res_reg[0];
            m_pos_y     <= res_reg[1];
            m_vel_x     <= res_reg[2];
            m_vel_y     <= res_reg[3];
            m_acc_x     <= res_reg[4];
            m_acc_y     <= res_reg[5];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/spe_checker.sv =====
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks of the spline path evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "spline_path_eval_at_arc_length_macros.svh"

module spe_checker import spe_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_op,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_valid_res,
    input logic [SEG_BITS-1:0]  m_seg_found,
    input logic [FRAC_BITS:0]   m_u_param,
    input logic [WORD_BITS-1:0] m_pos_x,
    input logic [WORD_BITS-1:0] m_pos_y
);

    localparam logic [FRAC_BITS:0] U_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    `SPE_ASSERT_NXT(a_hold_valid, m_valid && !m_ready, m_valid)
    `SPE_ASSERT_NXT(a_hold_pos, m_valid && !m_ready, $stable(m_pos_x) && $stable(m_pos_y))
    `SPE_ASSERT_IMP(a_empty_zero, m_valid && !m_valid_res, (m_u_param == '0) && (m_seg_found == '0) && (m_pos_x == '0) && (m_pos_y == '0))
    `SPE_ASSERT_IMP(a_u_range, m_valid && m_valid_res, m_u_param <= U_ONE)
    `SPE_ASSERT_NXT(a_busy_eval, s_valid && s_ready && (s_op == OP_EVAL), !s_ready)

endmodule

bind spline_path_eval_at_arc_length spe_checker #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
) u_spe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_valid_res (m_valid_res),
    .m_seg_found (m_seg_found),
    .m_u_param   (m_u_param),
    .m_pos_x     (m_pos_x),
    .m_pos_y     (m_pos_y)
);
